@@ rtl/sftp_pkg.sv @@
`default_nettype none
package sftp_pkg;

    localparam int WORD_W = 32;
    localparam int CFG_IDX_W = 4;

    localparam int DEF_BLOCKS = 156;
    localparam int DEF_MIDDLE_OFFSET = 122;
    localparam int DEF_WORD_LEFT_SHIFT = 18;
    localparam int DEF_BYTE_LEFT_SHIFT = 1;
    localparam int DEF_MASKED_RIGHT_SHIFT = 11;
    localparam int DEF_WORD_RIGHT_SHIFT = 1;

    localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;
    localparam int SEED_SHIFT = 30;

    localparam logic [WORD_W-1:0] MASK0_RST = 32'd3758096367;
    localparam logic [WORD_W-1:0] MASK1_RST = 32'd3724462975;
    localparam logic [WORD_W-1:0] MASK2_RST = 32'd3220897791;
    localparam logic [WORD_W-1:0] MASK3_RST = 32'd3221225462;
    localparam logic [WORD_W-1:0] PAR0_RST = 32'd1;
    localparam logic [WORD_W-1:0] PAR1_RST = 32'd0;
    localparam logic [WORD_W-1:0] PAR2_RST = 32'd0;
    localparam logic [WORD_W-1:0] PAR3_RST = 32'd331998852;

    localparam logic [CFG_IDX_W-1:0] REG_MASK0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK3 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAR0 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAR1 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAR2 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PAR3 = 4'd7;

    localparam logic MODE_DRAW = 1'b0;
    localparam logic MODE_SEED = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [3:0] t_block;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_CERT,
        ST_PRE_RD,
        ST_BLK_RD,
        ST_BLK_COMP,
        ST_BLK_WR,
        ST_DRAW_RD,
        ST_DRAW_CAP,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

@@ rtl/sftp_mem.sv @@
`default_nettype none
module sftp_mem #(
    parameter int DEPTH = 624,
    parameter int AW = 10
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire sftp_pkg::t_word           i_wdata,
    input  wire logic [AW-1:0]             i_raddr_a,
    input  wire logic [AW-1:0]             i_raddr_b,
    output sftp_pkg::t_word                o_rdata_a,
    output sftp_pkg::t_word                o_rdata_b
);
    import sftp_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rd_a;
    t_word r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule
`default_nettype wire

@@ rtl/simd_fast_twister_prng_top.sv @@
// Draw: an item runs ST_DRAW_RD, ST_DRAW_CAP and ST_EMIT, which registers the
// result once the output is free; a new item is taken only in ST_IDLE, and a
// draw before any seed goes straight to ST_EMIT. A draw that exhausts the buffer
// first runs a regeneration pass over the state RAM (two read ports, one write
// port, 4 words per block). Reseed: one 32x32 multiply and one add per state
// word after the seed. Synchronous active-low reset; state RAM is not cleared,
// draws before a seed return zero with o_unseeded set.
`default_nettype none
module simd_fast_twister_prng_top #(
    parameter int BLOCKS = sftp_pkg::DEF_BLOCKS,
    parameter int MIDDLE_OFFSET = sftp_pkg::DEF_MIDDLE_OFFSET,
    parameter int WORD_LEFT_SHIFT = sftp_pkg::DEF_WORD_LEFT_SHIFT,
    parameter int BYTE_LEFT_SHIFT = sftp_pkg::DEF_BYTE_LEFT_SHIFT,
    parameter int MASKED_RIGHT_SHIFT = sftp_pkg::DEF_MASKED_RIGHT_SHIFT,
    parameter int WORD_RIGHT_SHIFT = sftp_pkg::DEF_WORD_RIGHT_SHIFT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_mode,
    input  wire logic [31:0]                      i_seed,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [31:0]                           o_random_word,
    output logic                                  o_unseeded,
    input  wire logic                             i_cfg_we,
    input  wire logic [sftp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [31:0]                      i_cfg_data
);
    import sftp_pkg::*;

    localparam int DRAW_WORDS = BLOCKS * 4;
    localparam int NWORDS = (BLOCKS + 1) * 4;
    localparam int AW = $clog2(DRAW_WORDS);
    localparam int IW = $clog2(BLOCKS);
    localparam int CW = $clog2(NWORDS);
    localparam int PW = $clog2(DRAW_WORDS + 1);
    localparam int LSH = BYTE_LEFT_SHIFT * 8;
    localparam logic [IW-1:0] LAST_BLK = IW'(BLOCKS - 1);
    localparam logic [IW-1:0] MID_START = IW'(MIDDLE_OFFSET % BLOCKS);
    localparam logic [PW-1:0] POS_END = PW'(DRAW_WORDS);
    localparam logic [CW-1:0] CNT_LAST = CW'(NWORDS - 1);
    localparam logic [CW-1:0] CNT_DRAW = CW'(DRAW_WORDS);

    t_state r_state, n_state;
    t_block r_mask, r_par;
    t_block r_last, r_a, r_b, r_c, r_v;
    t_word r_prev, r_prod, r_res_word;
    logic r_res_flag, r_seeded;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_pos;
    logic [IW-1:0] r_i, r_bi;
    logic [2:0] r_k;
    t_word r_out_word;
    logic r_out_flag, r_out_valid;

    logic mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
    t_word mem_wdata, rd_a, rd_b, seed_word;
    logic [1:0] cap_k;
    logic out_free;
    t_block v_blk, cert_last;
    logic [127:0] a_shl;
    t_word par_acc;
    logic found;
    t_word lowbit;

    sftp_mem #(.DEPTH(DRAW_WORDS), .AW(AW)) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_raddr_a(mem_raddr_a),
        .i_raddr_b(mem_raddr_b),
        .o_rdata_a(rd_a),
        .o_rdata_b(rd_b)
    );

    assign cap_k = 2'(r_k - 3'd1);
    assign out_free = !r_out_valid || i_ready;
    assign seed_word = r_prod + t_word'(r_cnt);
    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_random_word = r_out_word;
    assign o_unseeded = r_out_flag;

    // 128-bit block recursion
    always_comb begin
        a_shl = {r_a[3], r_a[2], r_a[1], r_a[0]} << LSH;
        v_blk[0] = r_a[0] ^ a_shl[31:0] ^ ((r_b[0] >> MASKED_RIGHT_SHIFT) & r_mask[0])
            ^ (r_c[0] >> WORD_RIGHT_SHIFT) ^ (r_c[0] << WORD_LEFT_SHIFT) ^ r_last[3];
        v_blk[1] = r_a[1] ^ a_shl[63:32] ^ ((r_b[1] >> MASKED_RIGHT_SHIFT) & r_mask[1])
            ^ (r_c[1] >> WORD_RIGHT_SHIFT) ^ (r_c[1] << WORD_LEFT_SHIFT) ^ r_last[2];
        v_blk[2] = r_a[2] ^ a_shl[95:64] ^ ((r_b[2] >> MASKED_RIGHT_SHIFT) & r_mask[2])
            ^ (r_c[2] >> WORD_RIGHT_SHIFT) ^ (r_c[2] << WORD_LEFT_SHIFT) ^ r_last[0];
        v_blk[3] = r_a[3] ^ a_shl[127:96] ^ ((r_b[3] >> MASKED_RIGHT_SHIFT) & r_mask[3])
            ^ (r_c[3] >> WORD_RIGHT_SHIFT) ^ (r_c[3] << WORD_LEFT_SHIFT) ^ r_last[1];
    end

    // period certification: flip lowest parity bit if parity is even
    always_comb begin
        par_acc = '0;
        found = 1'b0;
        lowbit = '0;
        cert_last = r_last;
        for (int k = 0; k < 4; k++) begin
            par_acc ^= r_last[k] & r_par[k];
        end
        if (!(^par_acc)) begin
            for (int k = 0; k < 4; k++) begin
                lowbit = r_par[k] & (~r_par[k] + 32'd1);
                if (!found && r_par[k] != '0) begin
                    cert_last[k] = r_last[k] ^ lowbit;
                    found = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        mem_we = 1'b0;
        mem_waddr = r_cnt[AW-1:0];
        mem_wdata = seed_word;
        mem_raddr_a = {r_i, r_k[1:0]};
        mem_raddr_b = {r_bi, r_k[1:0]};
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_mode == MODE_SEED) begin
                        mem_we = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = i_seed;
                        n_state = ST_SEED_MUL;
                    end else if (!r_seeded) begin
                        n_state = ST_EMIT;
                    end else if (r_pos >= POS_END) begin
                        n_state = ST_PRE_RD;
                    end else begin
                        n_state = ST_DRAW_RD;
                    end
                end
            end
            ST_SEED_MUL: n_state = ST_SEED_ADD;
            ST_SEED_ADD: begin
                mem_we = (r_cnt < CNT_DRAW);
                n_state = (r_cnt == CNT_LAST) ? ST_CERT : ST_SEED_MUL;
            end
            ST_CERT: n_state = ST_IDLE;
            ST_PRE_RD: begin
                mem_raddr_a = {LAST_BLK, r_k[1:0]};
                if (r_k == 3'd4) begin
                    n_state = ST_BLK_RD;
                end
            end
            ST_BLK_RD: begin
                if (r_k == 3'd4) begin
                    n_state = ST_BLK_COMP;
                end
            end
            ST_BLK_COMP: n_state = ST_BLK_WR;
            ST_BLK_WR: begin
                mem_we = 1'b1;
                mem_waddr = {r_i, r_k[1:0]};
                mem_wdata = r_v[r_k[1:0]];
                if (r_k == 3'd3) begin
                    n_state = (r_i == LAST_BLK) ? ST_DRAW_RD : ST_BLK_RD;
                end
            end
            ST_DRAW_RD: begin
                mem_raddr_a = r_pos[AW-1:0];
                n_state = ST_DRAW_CAP;
            end
            ST_DRAW_CAP: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= {MASK3_RST, MASK2_RST, MASK1_RST, MASK0_RST};
            r_par <= {PAR3_RST, PAR2_RST, PAR1_RST, PAR0_RST};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MASK0: r_mask[0] <= i_cfg_data;
                REG_MASK1: r_mask[1] <= i_cfg_data;
                REG_MASK2: r_mask[2] <= i_cfg_data;
                REG_MASK3: r_mask[3] <= i_cfg_data;
                REG_PAR0: r_par[0] <= i_cfg_data;
                REG_PAR1: r_par[1] <= i_cfg_data;
                REG_PAR2: r_par[2] <= i_cfg_data;
                REG_PAR3: r_par[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
            r_pos <= POS_END;
            r_out_valid <= 1'b0;
            r_k <= '0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_k <= '0;
                    r_i <= '0;
                    r_bi <= MID_START;
                    r_prev <= i_seed;
                    r_cnt <= CW'(1);
                    r_res_word <= '0;
                    r_res_flag <= 1'b1;
                end
                ST_SEED_MUL: begin
                    r_prod <= SEED_MULT * (r_prev ^ (r_prev >> SEED_SHIFT));
                end
                ST_SEED_ADD: begin
                    r_prev <= seed_word;
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt >= CNT_DRAW) begin
                        r_last[r_cnt[1:0]] <= seed_word;
                    end
                end
                ST_CERT: begin
                    r_last <= cert_last;
                    r_seeded <= 1'b1;
                    r_pos <= POS_END;
                end
                ST_PRE_RD: begin
                    if (r_k != 3'd0) begin
                        r_c[cap_k] <= rd_a;
                    end
                    r_k <= (r_k == 3'd4) ? 3'd0 : r_k + 3'd1;
                end
                ST_BLK_RD: begin
                    if (r_k != 3'd0) begin
                        r_a[cap_k] <= rd_a;
                        r_b[cap_k] <= rd_b;
                    end
                    r_k <= (r_k == 3'd4) ? 3'd0 : r_k + 3'd1;
                end
                ST_BLK_COMP: begin
                    r_v <= v_blk;
                    r_c <= v_blk;
                    for (int k = 0; k < 4; k++) begin
                        r_last[k] <= r_last[k] ^ v_blk[k];
                    end
                end
                ST_BLK_WR: begin
                    if (r_k == 3'd3) begin
                        r_k <= '0;
                        r_i <= r_i + IW'(1);
                        r_bi <= (r_bi == LAST_BLK) ? '0 : r_bi + IW'(1);
                        if (r_i == LAST_BLK) begin
                            r_pos <= '0;
                        end
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                ST_DRAW_CAP: begin
                    r_res_word <= rd_a;
                    r_res_flag <= 1'b0;
                    r_pos <= r_pos + PW'(1);
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_word <= r_res_word;
                        r_out_flag <= r_res_flag;
                    end
                end
                default: ;
            endcase
        end
    end

    a_unseeded_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_unseeded |-> o_random_word == '0)
        else $error("unseeded item carries a nonzero word");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_END)
        else $error("read position past end of buffer");

    a_cert_seeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CERT |=> r_seeded && r_pos == POS_END)
        else $error("reseed did not arm regeneration");

    a_regen_seeded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PRE_RD || r_state == ST_DRAW_RD) |-> r_seeded)
        else $error("state RAM read before any seed");

endmodule
`default_nettype wire
